FILE: hdl/okvt_pkg.sv
// Shared types and codes for the ordered key/value table.
`timescale 1ns / 1ps

package okvt_pkg;

   // request modes as they arrive on the request word
   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_UPDATE = 3'd1;
   localparam logic [2:0] MODE_UPSERT = 3'd2;
   localparam logic [2:0] MODE_ERASE  = 3'd3;
   localparam logic [2:0] MODE_LOOKUP = 3'd4;
   localparam logic [2:0] MODE_FETCH  = 3'd5;

   // operations as queued for the back end
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_UPSERT = 3'd2;
   localparam logic [2:0] OP_ERASE  = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;
   localparam logic [2:0] OP_FETCH  = 3'd5;
   localparam logic [2:0] OP_NOP    = 3'd7;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_PRESENT   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] key_in;
      logic [31:0] value_in;
      logic [3:0]  position;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] key_out;
      logic [31:0] value_out;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] key_in;
      logic [31:0] value_in;
      logic [3:0]  position;
   } cmd_type;

   // queue head handed from front end to back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

FILE: hdl/okvt_front.sv
// Front end: takes request words, classifies the mode and queues commands.
`timescale 1ns / 1ps

module okvt_front import okvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output head_type head,
   input  logic     pop
);

   localparam int QUEUE_DEPTH = 2;
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        q_ff [QUEUE_DEPTH];
   cmd_type        q_in [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           push;
   cmd_type        entry;

   assign busy = (count_ff == QCW'(QUEUE_DEPTH));
   assign push = start & ~busy;

   // map the mode onto an operation; unused modes become a no-op
   always_comb begin
      entry.key_in   = req_data.key_in;
      entry.value_in = req_data.value_in;
      entry.position = req_data.position;
      case (req_data.mode)
         MODE_INSERT: entry.op = OP_INSERT;
         MODE_UPDATE: entry.op = OP_UPDATE;
         MODE_UPSERT: entry.op = OP_UPSERT;
         MODE_ERASE:  entry.op = OP_ERASE;
         MODE_LOOKUP: entry.op = OP_LOOKUP;
         MODE_FETCH:  entry.op = OP_FETCH;
         default:     entry.op = OP_NOP;
      endcase
   end

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         q_in[wr_ptr_ff] = entry;
         wr_ptr_in       = wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QAW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("command queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("command queue count beyond depth");

endmodule

FILE: hdl/okvt_back.sv
// Back end: holds the ordered slots, matches keys and carries out commands.
`timescale 1ns / 1ps

module okvt_back import okvt_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 4) ? CW : 4;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                   state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [CAPACITY-1:0]    match_ff, match_in;
   logic [KEY_WIDTH-1:0]   key_slot_ff [CAPACITY];
   logic [KEY_WIDTH-1:0]   key_slot_in [CAPACITY];
   logic [VALUE_WIDTH-1:0] value_slot_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] value_slot_in [CAPACITY];
   logic [CW-1:0]          occ_ff, occ_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [KEY_WIDTH-1:0]   head_key;
   logic [KEY_WIDTH-1:0]   cmd_key;
   logic [VALUE_WIDTH-1:0] cmd_value;
   logic                   found;
   logic                   full;
   logic [IW-1:0]          hit_idx;
   logic [IW-1:0]          pos_idx;
   logic                   pos_ok;

   assign head_key  = KEY_WIDTH'(head.cmd.key_in);
   assign cmd_key   = KEY_WIDTH'(cmd_ff.key_in);
   assign cmd_value = VALUE_WIDTH'(cmd_ff.value_in);
   assign found     = |match_ff;
   assign full      = (occ_ff == CW'(CAPACITY));
   assign pos_idx   = IW'(cmd_ff.position);
   assign pos_ok    = (PW'(cmd_ff.position) < PW'(occ_ff));

   // keys are unique, so at most one match bit is set: encode by OR
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_ff[i]) begin
            hit_idx = hit_idx | IW'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      match_in      = match_ff;
      key_slot_in   = key_slot_ff;
      value_slot_in = value_slot_ff;
      occ_in        = occ_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cmd_in = head.cmd;
               for (int i = 0; i < CAPACITY; i++) begin
                  match_in[i] = (CW'(i) < occ_ff) && (key_slot_ff[i] == head_key);
               end
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in           = S_IDLE;
            rsp_valid_in       = 1'b1;
            rsp_in.status      = ST_OK;
            rsp_in.key_out     = '0;
            rsp_in.value_out   = '0;
            case (cmd_ff.op)
               OP_INSERT, OP_UPSERT: begin
                  if (found) begin
                     if (cmd_ff.op == OP_INSERT) begin
                        rsp_in.status = ST_PRESENT;
                     end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                           if (match_ff[i]) value_slot_in[i] = cmd_value;
                        end
                     end
                  end else if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     // push every entry back by one and place the new pair in front
                     for (int i = CAPACITY - 1; i > 0; i--) begin
                        key_slot_in[i]   = key_slot_ff[i-1];
                        value_slot_in[i] = value_slot_ff[i-1];
                     end
                     key_slot_in[0]   = cmd_key;
                     value_slot_in[0] = cmd_value;
                     occ_in           = occ_ff + CW'(1);
                  end
               end
               OP_UPDATE: begin
                  if (!found) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (match_ff[i]) value_slot_in[i] = cmd_value;
                     end
                  end
               end
               OP_ERASE: begin
                  if (!found) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     // close the gap: pull every later entry forward by one
                     for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (IW'(i) >= hit_idx) begin
                           key_slot_in[i]   = key_slot_ff[i+1];
                           value_slot_in[i] = value_slot_ff[i+1];
                        end
                     end
                     occ_in = occ_ff - CW'(1);
                  end
               end
               OP_LOOKUP: begin
                  if (!found) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     rsp_in.value_out = 32'(value_slot_ff[hit_idx]);
                  end
               end
               OP_FETCH: begin
                  if (pos_ok) begin
                     rsp_in.key_out   = 32'(key_slot_ff[pos_idx]);
                     rsp_in.value_out = 32'(value_slot_ff[pos_idx]);
                  end else begin
                     rsp_in.status = ST_RANGE;
                  end
               end
               default: begin
               end
            endcase
            rsp_in.entry_count = 5'(occ_in);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      match_ff      <= match_in;
      key_slot_ff   <= key_slot_in;
      value_slot_ff <= value_slot_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC))
      else $error("result strobe without an executed command");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> $onehot0(match_ff))
      else $error("key matched in more than one slot");

endmodule

FILE: hdl/ordered_key_value_table.sv
// Top level of the ordered key/value table: front end, command queue and back end.
`timescale 1ns / 1ps
//
//  channel   ports                        handshake
//  request   start, busy, req_data        taken when start && !busy
//  result    rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//
//  The back end pops one command at a time: in idle it compares the key against
//  every slot in parallel, in execute it shifts or writes the slots. The result
//  strobe follows the taken request through the queue, match and result registers.
//  busy rises only while the two-entry command queue is full.
//  Synchronous reset empties the table; slot contents need no clearing.
//
module ordered_key_value_table import okvt_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   head_type head;
   logic     pop;

   okvt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .head     (head),
      .pop      (pop)
   );

   okvt_back #(
      .CAPACITY    (CAPACITY),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
